// File: rtl/resp_binary_message_framer_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef RESP_BINARY_MESSAGE_FRAMER_MACROS_SVH
`define RESP_BINARY_MESSAGE_FRAMER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define RBMF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("framer check failed");

// Same-cycle implication
`define RBMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer implication failed");

// Next-cycle implication
`define RBMF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer next-cycle check failed");

`endif

// File: rtl/resp_bmf_pkg.sv
package resp_bmf_pkg;

  // Default build parameters
  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  // Field widths
  localparam int unsigned NUM_W      = 25;
  localparam int unsigned MAX_LEN_W  = 24;
  localparam int unsigned MAX_ARGS_W = 16;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned HDR_W      = 5;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Bytes of the big-endian length field of a binary message
  localparam int unsigned LEN_FIELD_BYTES = 4;
  // Shortest RESP buffer that may give a verdict of ok
  localparam int unsigned RESP_MIN_BYTES  = 4;
  localparam int unsigned DEC_BASE        = 10;

  localparam logic [NUM_W-1:0]      NUM_SAT       = 25'h1FFFFFF;
  localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RST   = 24'd1048576;
  localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RST  = 16'd256;

  // Characters of the RESP grammar
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Verdict codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_TOO_BIG    = 2'd2;

  localparam logic KIND_RESP   = 1'b0;
  localparam logic KIND_BINARY = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_LEN  = 1'b0;
  localparam logic REG_MAX_ARGS = 1'b1;

  // Packed result layout on the master tdata
  localparam int unsigned OUT_ST_LSB    = 0;
  localparam int unsigned OUT_HDR_LSB   = 2;
  localparam int unsigned OUT_PAY_LSB   = 7;
  localparam int unsigned OUT_TOT_LSB   = 39;
  localparam int unsigned OUT_TDATA_W   = 72;

  typedef enum logic [11:0] {
    P_FIRST      = 12'b0000_0000_0001,
    P_CNT_START  = 12'b0000_0000_0010,
    P_CNT_DIGITS = 12'b0000_0000_0100,
    P_CNT_LF     = 12'b0000_0000_1000,
    P_ARG_DOLLAR = 12'b0000_0001_0000,
    P_LEN_START  = 12'b0000_0010_0000,
    P_LEN_DIGITS = 12'b0000_0100_0000,
    P_LEN_LF     = 12'b0000_1000_0000,
    P_DATA       = 12'b0001_0000_0000,
    P_TAIL_CR    = 12'b0010_0000_0000,
    P_TAIL_LF    = 12'b0100_0000_0000,
    P_BIN        = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    OC_RUNNING = 3'b001,
    OC_DONE    = 3'b010,
    OC_FAILED  = 3'b100
  } outcome_e;

  typedef struct packed {
    logic [MAX_LEN_W-1:0]  max_message_len;
    logic [MAX_ARGS_W-1:0] max_args;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             kind;
    logic [HDR_W-1:0] hdr_bytes;
    logic [LEN_W-1:0] body_bytes;
    logic [LEN_W-1:0] frame_bytes;
  } result_t;

  // Verdict request from the scanner to the output stage
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_req_t;

endpackage

// File: rtl/resp_bmf_cfg.sv
module resp_bmf_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [resp_bmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [resp_bmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [resp_bmf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output resp_bmf_pkg::cfg_t                   cfg_o
);
  import resp_bmf_pkg::*;

  logic [MAX_LEN_W-1:0]  max_len_q;
  logic [MAX_ARGS_W-1:0] max_args_q;
  logic                  wr_en;
  logic                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MAX_LEN_RST;
      max_args_q <= MAX_ARGS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_LEN:  max_len_q  <= pwdata[MAX_LEN_W-1:0];
        REG_MAX_ARGS: max_args_q <= pwdata[MAX_ARGS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_MAX_LEN:  prdata = APB_DATA_W'(max_len_q);
      REG_MAX_ARGS: prdata = APB_DATA_W'(max_args_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.max_message_len = max_len_q;
  assign cfg_o.max_args        = max_args_q;

endmodule

// File: rtl/resp_bmf_scan.sv
module resp_bmf_scan #(
  parameter int unsigned HEADER_BYTES = resp_bmf_pkg::HEADER_BYTES_DEF,
  parameter int unsigned COUNT_WIDTH  = resp_bmf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  input  resp_bmf_pkg::cfg_t        cfg_i,
  output resp_bmf_pkg::result_req_t res_o,
  input  logic                      res_ready_i
);
  import resp_bmf_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] BC_MAX = {COUNT_WIDTH{1'b1}};

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;

  // Scanner state
  phase_e                 phase_q, phase_d;
  outcome_e               outcome_q, outcome_d;
  logic [COUNT_WIDTH-1:0] bc_q, bc_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [NUM_W-1:0]       nv_q, nv_d;
  logic                   neg_q, neg_d;
  logic [MAX_ARGS_W-1:0]  args_q, args_d;
  logic [MAX_LEN_W-1:0]   dl_q, dl_d;
  logic [LEN_W-1:0]       bl_q, bl_d;
  logic                   kind_q, kind_d;

  // Number line helpers
  logic              num_start;
  logic              is_digit;
  logic [3:0]        digit;
  logic [NUM_W+3:0]  nv_prod;
  logic [NUM_W-1:0]  nv_acc;
  logic              nv_bad_sign;
  logic [MAX_LEN_W-1:0]  dl_m1;
  logic [MAX_ARGS_W-1:0] args_m1;

  // Verdict
  logic [LEN_W-1:0] bc_ext;
  logic [LEN_W-1:0] bin_total;
  result_t          verdict;

  // A byte without a verdict never waits on the output side
  assign advance    = in_valid_q && (!in_last_q || res_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // Decimal accumulate with saturation
  assign num_start   = (phase_q == P_CNT_START) || (phase_q == P_LEN_START);
  assign is_digit    = (in_byte_q >= CH_ZERO) && (in_byte_q <= CH_NINE);
  assign digit       = 4'(in_byte_q - CH_ZERO);
  assign nv_prod     = (NUM_W+4)'(nv_q) * (NUM_W+4)'(DEC_BASE) + (NUM_W+4)'(digit);
  assign nv_acc      = (nv_prod > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT : nv_prod[NUM_W-1:0];
  assign nv_bad_sign = neg_q && (nv_q != '0);
  assign dl_m1       = dl_q - 1'b1;
  assign args_m1     = args_q - 1'b1;

  // Next state for the byte in the input register
  always_comb begin
    phase_d   = phase_q;
    outcome_d = outcome_q;
    total_d   = total_q;
    nv_d      = nv_q;
    neg_d     = neg_q;
    args_d    = args_q;
    dl_d      = dl_q;
    bl_d      = bl_q;
    kind_d    = kind_q;
    bc_d      = (bc_q != BC_MAX) ? bc_q + 1'b1 : bc_q;

    case (phase_q)
      P_FIRST: begin
        if (in_byte_q == CH_STAR) begin
          kind_d  = KIND_RESP;
          nv_d    = '0;
          neg_d   = 1'b0;
          phase_d = P_CNT_START;
        end else begin
          kind_d  = KIND_BINARY;
          bl_d    = LEN_W'(in_byte_q);
          phase_d = P_BIN;
        end
      end
      P_BIN: begin
        if (bc_q < COUNT_WIDTH'(LEN_FIELD_BYTES)) begin
          bl_d = {bl_q[LEN_W-9:0], in_byte_q};
        end
      end
      default: begin
        if (outcome_q == OC_RUNNING) begin
          case (phase_q)
            P_CNT_START, P_CNT_DIGITS: begin
              if (num_start && in_byte_q == CH_MINUS) begin
                neg_d   = 1'b1;
                phase_d = P_CNT_DIGITS;
              end else if (in_byte_q == CH_CR) begin
                phase_d = P_CNT_LF;
              end else if (is_digit) begin
                nv_d    = nv_acc;
                phase_d = P_CNT_DIGITS;
              end else begin
                outcome_d = OC_FAILED;
              end
            end
            P_CNT_LF: begin
              if (in_byte_q != CH_LF || nv_bad_sign ||
                  nv_q > NUM_W'(cfg_i.max_args)) begin
                outcome_d = OC_FAILED;
              end else if (nv_q == '0) begin
                outcome_d = OC_DONE;
                total_d   = bc_d;
              end else begin
                args_d  = nv_q[MAX_ARGS_W-1:0];
                phase_d = P_ARG_DOLLAR;
              end
            end
            P_ARG_DOLLAR: begin
              if (in_byte_q == CH_DOLLAR) begin
                nv_d    = '0;
                neg_d   = 1'b0;
                phase_d = P_LEN_START;
              end else begin
                outcome_d = OC_FAILED;
              end
            end
            P_LEN_START, P_LEN_DIGITS: begin
              if (num_start && in_byte_q == CH_MINUS) begin
                neg_d   = 1'b1;
                phase_d = P_LEN_DIGITS;
              end else if (in_byte_q == CH_CR) begin
                phase_d = P_LEN_LF;
              end else if (is_digit) begin
                nv_d    = nv_acc;
                phase_d = P_LEN_DIGITS;
              end else begin
                outcome_d = OC_FAILED;
              end
            end
            P_LEN_LF: begin
              if (in_byte_q != CH_LF || nv_bad_sign ||
                  nv_q > NUM_W'(cfg_i.max_message_len)) begin
                outcome_d = OC_FAILED;
              end else begin
                dl_d    = nv_q[MAX_LEN_W-1:0];
                phase_d = (nv_q != '0) ? P_DATA : P_TAIL_CR;
              end
            end
            P_DATA: begin
              dl_d = dl_m1;
              if (dl_m1 == '0) begin
                phase_d = P_TAIL_CR;
              end
            end
            P_TAIL_CR: begin
              if (in_byte_q == CH_CR) begin
                phase_d = P_TAIL_LF;
              end else begin
                outcome_d = OC_FAILED;
              end
            end
            P_TAIL_LF: begin
              if (in_byte_q != CH_LF) begin
                outcome_d = OC_FAILED;
              end else begin
                args_d = args_m1;
                if (args_m1 == '0) begin
                  outcome_d = OC_DONE;
                  total_d   = bc_d;
                end else begin
                  phase_d = P_ARG_DOLLAR;
                end
              end
            end
            default: outcome_d = OC_FAILED;
          endcase
        end
      end
    endcase
  end

  // Verdict from the updated state
  assign bc_ext    = LEN_W'(bc_d);
  assign bin_total = LEN_W'(HEADER_BYTES) + bl_d;

  always_comb begin
    verdict.status      = ST_INCOMPLETE;
    verdict.kind        = kind_d;
    verdict.hdr_bytes   = '0;
    verdict.body_bytes  = '0;
    verdict.frame_bytes = '0;
    if (kind_d == KIND_RESP) begin
      if (outcome_d == OC_DONE && bc_ext >= LEN_W'(RESP_MIN_BYTES)) begin
        verdict.status      = ST_OK;
        verdict.body_bytes  = LEN_W'(total_d);
        verdict.frame_bytes = LEN_W'(total_d);
      end
    end else if (bc_ext >= LEN_W'(HEADER_BYTES)) begin
      if (bl_d > LEN_W'(cfg_i.max_message_len)) begin
        verdict.status = ST_TOO_BIG;
      end else begin
        verdict.status      = (bc_ext < bin_total) ? ST_INCOMPLETE : ST_OK;
        verdict.hdr_bytes   = HDR_W'(HEADER_BYTES);
        verdict.body_bytes  = bl_d;
        verdict.frame_bytes = bin_total;
      end
    end
  end

  assign res_o.valid = advance && in_last_q;
  assign res_o.data  = verdict;

  // Advance the state; clear it after the last byte of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= P_FIRST;
      outcome_q <= OC_RUNNING;
      bc_q      <= '0;
      total_q   <= '0;
      nv_q      <= '0;
      neg_q     <= 1'b0;
      args_q    <= '0;
      dl_q      <= '0;
      bl_q      <= '0;
      kind_q    <= KIND_RESP;
    end else if (advance) begin
      if (in_last_q) begin
        phase_q   <= P_FIRST;
        outcome_q <= OC_RUNNING;
        bc_q      <= '0;
        total_q   <= '0;
        nv_q      <= '0;
        neg_q     <= 1'b0;
        args_q    <= '0;
        dl_q      <= '0;
        bl_q      <= '0;
        kind_q    <= KIND_RESP;
      end else begin
        phase_q   <= phase_d;
        outcome_q <= outcome_d;
        bc_q      <= bc_d;
        total_q   <= total_d;
        nv_q      <= nv_d;
        neg_q     <= neg_d;
        args_q    <= args_d;
        dl_q      <= dl_d;
        bl_q      <= bl_d;
        kind_q    <= kind_d;
      end
    end
  end

endmodule

// File: rtl/resp_bmf_out.sv
module resp_bmf_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  resp_bmf_pkg::result_req_t             res_i,
  output logic                                  res_ready_o,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [resp_bmf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                  m_axis_tuser
);
  import resp_bmf_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Free slot, or the held result leaves this cycle
  assign res_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.valid) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = data_q.kind;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_TOT_LSB - LEN_W)'(0),
                          data_q.frame_bytes, data_q.body_bytes,
                          data_q.hdr_bytes, data_q.status};

endmodule

// File: rtl/resp_binary_message_framer.sv
// Channel   | Direction | Payload
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tdata[7:0] data_byte; tlast end_of_buffer
// m_axis    | out       | tdata status, hdr_bytes, body_bytes, frame_bytes;
//           |           | tuser kind
// APB       | in        | 0x0 max_message_len, 0x4 max_args
//
// One byte is accepted every cycle while no byte marked last waits on a full output register;
// the byte is held in an input register and scanned in the next cycle, and the verdict
// is held in the output register while it is offered on m_axis.
// The scan of one byte (decimal accumulate, limit compares) sets the clock period.
// rst_ni clears the scanner, both channel registers and the limits to their defaults.
// Only a byte marked last waits for the output register; other bytes flow through
// while a verdict is stalled on m_axis.
module resp_binary_message_framer #(
  parameter int unsigned HEADER_BYTES = resp_bmf_pkg::HEADER_BYTES_DEF,
  parameter int unsigned COUNT_WIDTH  = resp_bmf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // data_byte [7:0]
  input  logic [7:0]                            s_axis_tdata,
  input  logic                                  s_axis_tlast,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // status [1:0], hdr_bytes [6:2], body_bytes [38:7], frame_bytes [70:39], zero [71]
  output logic [resp_bmf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // kind [0]
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [resp_bmf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [resp_bmf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [resp_bmf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import resp_bmf_pkg::*;

  cfg_t        cfg;
  result_req_t res_req;
  logic        res_ready;

  resp_bmf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  resp_bmf_scan #(
    .HEADER_BYTES (HEADER_BYTES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_i       (cfg),
    .res_o       (res_req),
    .res_ready_i (res_ready)
  );

  resp_bmf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res_req),
    .res_ready_o   (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: rtl/resp_bmf_checker.sv
`include "resp_binary_message_framer_macros.svh"

module resp_bmf_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic [resp_bmf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                                  m_axis_tuser,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic                                  pready
);
  import resp_bmf_pkg::*;

  logic [1:0]       st;
  logic [HDR_W-1:0] hdr;
  logic [LEN_W-1:0] pay;
  logic [LEN_W-1:0] tot;
  logic             lens_zero;

  assign st        = m_axis_tdata[OUT_ST_LSB +: 2];
  assign hdr       = m_axis_tdata[OUT_HDR_LSB +: HDR_W];
  assign pay       = m_axis_tdata[OUT_PAY_LSB +: LEN_W];
  assign tot       = m_axis_tdata[OUT_TOT_LSB +: LEN_W];
  assign lens_zero = (hdr == '0) && (pay == '0) && (tot == '0);

  // A stalled verdict holds
  `RBMF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Only three verdict codes exist
  `RBMF_ASSERT_IMP(a_status_code, m_axis_tvalid,
                   st == ST_OK || st == ST_INCOMPLETE || st == ST_TOO_BIG)

  // A RESP verdict has no header and its payload is the whole message
  `RBMF_ASSERT_IMP(a_resp_shape, m_axis_tvalid && m_axis_tuser == KIND_RESP,
                   hdr == '0 && pay == tot)

  // Too big is binary only, and a too-big or incomplete RESP verdict carries no lengths
  `RBMF_ASSERT_IMP(a_fail_zero,
                   m_axis_tvalid && (st == ST_TOO_BIG ||
                   (st == ST_INCOMPLETE && m_axis_tuser == KIND_RESP)),
                   lens_zero && (st != ST_TOO_BIG || m_axis_tuser == KIND_BINARY))

  // The register port never waits
  `RBMF_ASSERT(a_pready, pready)

endmodule

bind resp_binary_message_framer resp_bmf_checker u_checker (.*);

// File: dv/resp_binary_message_framer_tb.sv
`timescale 1ns / 1ps

module resp_binary_message_framer_tb;
  import resp_bmf_pkg::*;

  localparam int unsigned HDR_BYTES = HEADER_BYTES_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef enum {DIG_MORE, DIG_CR, DIG_BAD} digit_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [7:0]             s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  resp_binary_message_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Stimulus and expectation stores
  byte_req_t   byte_reqs[$];
  result_t     verdicts_due[$];
  logic [7:0]  msg[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned verdicts_seen = 0;
  int unsigned ok_seen = 0;
  int unsigned short_seen = 0;
  int unsigned big_seen = 0;
  int unsigned binary_seen = 0;
  int unsigned src_wait = 0;
  int unsigned src_calm = 0;
  int unsigned snk_wait = 0;
  int unsigned snk_calm = 0;
  bit          stress_go = 1'b0;
  logic        hold_off = 1'b0;
  byte_req_t   next_req;
  result_t     fresh;
  result_t     want;

  // Framer state mirrored for prediction
  logic [MAX_LEN_W-1:0]  lim_len = MAX_LEN_RST;
  logic [MAX_ARGS_W-1:0] lim_args = MAX_ARGS_RST;
  phase_e                fr_phase = P_FIRST;
  outcome_e              fr_outcome = OC_RUNNING;
  logic [31:0]           fr_count = '0;
  logic [NUM_W-1:0]      fr_num = '0;
  logic                  fr_neg = 1'b0;
  logic [15:0]           fr_args = '0;
  logic [23:0]           fr_data = '0;
  logic [31:0]           fr_blen = '0;
  logic                  fr_kind = KIND_RESP;
  logic [31:0]           fr_total = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Drop all per-message state, ready for the next buffer
  function automatic void clear_frame();
    fr_phase   = P_FIRST;
    fr_outcome = OC_RUNNING;
    fr_count   = '0;
    fr_num     = '0;
    fr_neg     = 1'b0;
    fr_args    = '0;
    fr_data    = '0;
    fr_blen    = '0;
    fr_kind    = KIND_RESP;
    fr_total   = '0;
  endfunction

  // Accumulate one byte of a decimal line, saturating the value
  function automatic digit_e scan_digit(input logic [7:0] b, input bit at_start);
    logic [31:0] acc;
    if (at_start && b == CH_MINUS) begin
      fr_neg = 1'b1;
      return DIG_MORE;
    end
    if (b == CH_CR) return DIG_CR;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      acc = fr_num * DEC_BASE + (b - CH_ZERO);
      fr_num = (acc > NUM_SAT) ? NUM_SAT : acc[NUM_W-1:0];
      return DIG_MORE;
    end
    return DIG_BAD;
  endfunction

  function automatic void finish_frame();
    fr_outcome = OC_DONE;
    fr_total   = fr_count;
  endfunction

  // Advance the RESP grammar by one byte
  function automatic void resp_scan(input logic [7:0] b);
    digit_e r;
    case (fr_phase)
      P_CNT_START, P_CNT_DIGITS: begin
        r = scan_digit(b, fr_phase == P_CNT_START);
        if (r == DIG_BAD) fr_outcome = OC_FAILED;
        else if (r == DIG_CR) fr_phase = P_CNT_LF;
        else fr_phase = P_CNT_DIGITS;
      end
      P_CNT_LF: begin
        if (b != CH_LF || (fr_neg && fr_num != 0) || fr_num > lim_args) begin
          fr_outcome = OC_FAILED;
        end else if (fr_num == 0) begin
          finish_frame();
        end else begin
          fr_args  = fr_num[15:0];
          fr_phase = P_ARG_DOLLAR;
        end
      end
      P_ARG_DOLLAR: begin
        if (b == CH_DOLLAR) begin
          fr_num   = '0;
          fr_neg   = 1'b0;
          fr_phase = P_LEN_START;
        end else begin
          fr_outcome = OC_FAILED;
        end
      end
      P_LEN_START, P_LEN_DIGITS: begin
        r = scan_digit(b, fr_phase == P_LEN_START);
        if (r == DIG_BAD) fr_outcome = OC_FAILED;
        else if (r == DIG_CR) fr_phase = P_LEN_LF;
        else fr_phase = P_LEN_DIGITS;
      end
      P_LEN_LF: begin
        if (b != CH_LF || (fr_neg && fr_num != 0) || fr_num > lim_len) begin
          fr_outcome = OC_FAILED;
        end else begin
          fr_data = fr_num[23:0];
          if (fr_data != 0) fr_phase = P_DATA;
          else fr_phase = P_TAIL_CR;
        end
      end
      P_DATA: begin
        fr_data = fr_data - 1'b1;
        if (fr_data == 0) fr_phase = P_TAIL_CR;
      end
      P_TAIL_CR: begin
        if (b == CH_CR) fr_phase = P_TAIL_LF;
        else fr_outcome = OC_FAILED;
      end
      P_TAIL_LF: begin
        if (b != CH_LF) begin
          fr_outcome = OC_FAILED;
        end else begin
          fr_args = fr_args - 1'b1;
          if (fr_args == 0) finish_frame();
          else fr_phase = P_ARG_DOLLAR;
        end
      end
      default: fr_outcome = OC_FAILED;
    endcase
  endfunction

  // Take one accepted byte; returns 1 with the verdict on a last byte
  function automatic bit frame_byte(input logic [7:0] b, input logic last,
                                    output result_t verdict);
    logic [31:0] idx;
    logic [31:0] sum;
    idx = fr_count;
    if (fr_count != 32'hFFFF_FFFF) fr_count = fr_count + 1;
    if (fr_phase == P_FIRST) begin
      if (b == CH_STAR) begin
        fr_kind  = KIND_RESP;
        fr_num   = '0;
        fr_neg   = 1'b0;
        fr_phase = P_CNT_START;
      end else begin
        fr_kind  = KIND_BINARY;
        fr_phase = P_BIN;
        fr_blen  = {24'd0, b};
      end
    end else if (fr_phase == P_BIN) begin
      if (idx < LEN_FIELD_BYTES) fr_blen = {fr_blen[23:0], b};
    end else if (fr_outcome == OC_RUNNING) begin
      resp_scan(b);
    end
    if (!last) return 1'b0;

    verdict        = '0;
    verdict.status = ST_INCOMPLETE;
    verdict.kind   = fr_kind;
    if (fr_kind == KIND_RESP) begin
      if (fr_outcome == OC_DONE && fr_count >= RESP_MIN_BYTES) begin
        verdict.status      = ST_OK;
        verdict.body_bytes  = fr_total;
        verdict.frame_bytes = fr_total;
      end
    end else if (fr_count >= HDR_BYTES) begin
      if (fr_blen > {8'd0, lim_len}) begin
        verdict.status = ST_TOO_BIG;
      end else begin
        sum                 = HDR_BYTES + fr_blen;
        verdict.status      = (fr_count < sum) ? ST_INCOMPLETE : ST_OK;
        verdict.hdr_bytes   = HDR_W'(HDR_BYTES);
        verdict.body_bytes  = fr_blen;
        verdict.frame_bytes = sum;
      end
    end
    clear_frame();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // Idle cycles before the next request, with runs of back-to-back traffic
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 9) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Byte source: present queued requests and predict on every accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        if (frame_byte(s_axis_tdata, s_axis_tlast, fresh)) verdicts_due.push_back(fresh);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait != 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_reqs.size() != 0) begin
          next_req = byte_reqs.pop_front();
          s_axis_tdata  <= next_req.data;
          s_axis_tlast  <= next_req.last;
          s_axis_tvalid <= 1'b1;
          src_wait = draw_gap(src_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Verdict sink: compare each accepted verdict with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_seen++;
        if (m_axis_tdata[OUT_ST_LSB +: 2] == ST_OK) ok_seen++;
        else if (m_axis_tdata[OUT_ST_LSB +: 2] == ST_TOO_BIG) big_seen++;
        else short_seen++;
        if (m_axis_tuser == KIND_BINARY) binary_seen++;
        if (verdicts_due.size() == 0) begin
          $error("verdict with none expected: status %0d kind %0d",
                 m_axis_tdata[OUT_ST_LSB +: 2], m_axis_tuser);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", want.status, m_axis_tdata[OUT_ST_LSB +: 2]);
          check_field("kind", want.kind, m_axis_tuser);
          check_field("hdr_bytes", want.hdr_bytes, m_axis_tdata[OUT_HDR_LSB +: HDR_W]);
          check_field("body_bytes", want.body_bytes, m_axis_tdata[OUT_PAY_LSB +: LEN_W]);
          check_field("frame_bytes", want.frame_bytes, m_axis_tdata[OUT_TOT_LSB +: LEN_W]);
        end
        snk_wait = draw_gap(snk_calm);
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (snk_wait != 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long sink stall so the framer backs up onto its input
  initial begin
    wait (stress_go);
    repeat (30) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Write a limit register, then read it back
  task automatic cfg_write(input logic sel, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_MAX_LEN) lim_len = value[MAX_LEN_W-1:0];
    else lim_args = value[MAX_ARGS_W-1:0];
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (sel == REG_MAX_LEN) check_field("max_message_len readback", {8'd0, lim_len}, prdata);
    else check_field("max_args readback", {16'd0, lim_args}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_num(input int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_crlf();
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
  endtask

  task automatic push_msg();
    byte_req_t req;
    foreach (msg[i]) begin
      req.data = msg[i];
      req.last = (i == msg.size() - 1);
      byte_reqs.push_back(req);
    end
    bytes_queued += msg.size();
  endtask

  // RESP array, mostly well formed, with faults injected now and then
  task automatic gen_resp();
    int unsigned nargs;
    int unsigned len;
    int unsigned pick;
    int unsigned cap;
    msg.delete();
    msg.push_back(CH_STAR);
    pick = $urandom_range(0, 19);
    cap = (lim_args < 4) ? lim_args : 4;
    nargs = $urandom_range(0, cap);
    if (pick == 0) begin
      nargs = 0;
      msg.push_back(CH_MINUS);
      if ($urandom_range(0, 1) != 0) msg.push_back(CH_ZERO);
    end else if (pick == 1) begin
      msg.push_back(CH_MINUS);
      add_num($urandom_range(1, 9));
    end else if (pick == 2) begin
      add_num(lim_args + 1);
    end else if (pick == 3) begin
      add_text("123456789012");
    end else begin
      if (pick == 4) msg.push_back(CH_ZERO);
      add_num(nargs);
    end
    if (pick >= 1 && pick <= 3) nargs = 1;
    add_crlf();

    for (int i = 0; i < nargs; i++) begin
      msg.push_back(CH_DOLLAR);
      pick = $urandom_range(0, 15);
      cap = (lim_len < 6) ? lim_len : 6;
      len = $urandom_range(0, cap);
      if (pick == 12 && lim_len <= 40) begin
        len = lim_len;
        add_num(len);
      end else if (pick == 13) begin
        len = lim_len + 1;
        add_num(len);
      end else if (pick == 14) begin
        len = 0;
        msg.push_back(CH_MINUS);
        msg.push_back(CH_ZERO);
      end else if (pick == 15) begin
        len = 0;
        msg.push_back(CH_MINUS);
      end else begin
        add_num(len);
      end
      add_crlf();
      repeat ((len < 40) ? len : 40) msg.push_back(8'($urandom_range(0, 255)));
      add_crlf();
    end

    // Truncate, corrupt a byte or append trailing bytes
    pick = $urandom_range(0, 11);
    if (pick == 9) begin
      cap = $urandom_range(1, msg.size());
      while (msg.size() > cap) void'(msg.pop_back());
    end else if (pick == 10) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick == 11) begin
      repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom_range(0, 255)));
    end
    push_msg();
  endtask

  // Length-prefixed message with a body near, at or off its declared size
  task automatic gen_binary();
    logic [31:0] blen;
    int unsigned pick;
    int unsigned body;
    msg.delete();
    pick = $urandom_range(0, 11);
    blen = $urandom_range(0, 12);
    if (pick == 6) blen = lim_len;
    else if (pick == 7) blen = lim_len + 1;
    else if (pick == 8) blen = $urandom;
    else if (pick == 9) blen = 32'hFFFF_FFFF;
    for (int i = 3; i >= 0; i--) msg.push_back(blen[8*i +: 8]);
    body = (blen <= 40) ? blen : $urandom_range(0, 6);
    pick = $urandom_range(0, 7);
    if (pick == 0 && body != 0) body = body - $urandom_range(1, body);
    else if (pick == 1) body = body + $urandom_range(1, 4);
    repeat (body) msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      body = $urandom_range(1, 3);
      while (msg.size() > body) void'(msg.pop_back());
    end
    push_msg();
  endtask

  task automatic gen_noise();
    msg.delete();
    repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0) msg[0] = CH_STAR;
    push_msg();
  endtask

  // Hold until every byte is taken and every verdict checked
  task automatic drain();
    while (bytes_taken != bytes_queued || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) gen_resp();
      else if (pick < 17) gen_binary();
      else gen_noise();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed buffers at the reset limits
    msg = '{CH_STAR, CH_ZERO, CH_CR, CH_LF};
    push_msg();
    msg = '{CH_STAR, CH_MINUS, CH_CR, CH_LF};
    push_msg();
    msg = '{CH_STAR};
    push_msg();
    msg = '{8'h00, 8'h01};
    push_msg();
    msg = '{8'h00, 8'h00, 8'h00, 8'h00};
    push_msg();
    msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_msg();
    msg = '{CH_STAR, "1", CH_CR, CH_LF, CH_DOLLAR, CH_MINUS, CH_ZERO, CH_CR, CH_LF,
            CH_CR, CH_LF, 8'h00, 8'hFF};
    push_msg();
    msg = '{CH_STAR, CH_MINUS, "3", CH_CR, CH_LF};
    push_msg();
    msg = '{CH_STAR, "2", "x", CH_CR, CH_LF};
    push_msg();
    drain();

    // Random traffic over a spread of limit settings
    cfg_write(REG_MAX_LEN, 32'd16777214);
    cfg_write(REG_MAX_ARGS, 32'd65535);
    stress_go = 1'b1;
    random_phase(290);

    cfg_write(REG_MAX_LEN, 32'd0);
    cfg_write(REG_MAX_ARGS, 32'd0);
    random_phase(290);

    cfg_write(REG_MAX_LEN, 32'd5);
    cfg_write(REG_MAX_ARGS, 32'd2);
    random_phase(290);

    cfg_write(REG_MAX_LEN, $urandom_range(0, 40));
    cfg_write(REG_MAX_ARGS, $urandom_range(1, 6));
    random_phase(290);

    cfg_write(REG_MAX_LEN, {8'd0, MAX_LEN_RST});
    cfg_write(REG_MAX_ARGS, {16'd0, MAX_ARGS_RST});
    random_phase(290);

    $display("Framed %0d bytes into %0d verdicts (%0d ok, %0d incomplete, %0d too big)",
             bytes_taken, verdicts_seen, ok_seen, short_seen, big_seen);
    $display("Binary verdicts %0d, RESP verdicts %0d, over six limit settings",
             binary_seen, verdicts_seen - binary_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
